>>> sv/ts_packet_decapsulator_defines.svh
// Assertion macros shared by the decapsulator modules.
`ifndef TS_PACKET_DECAPSULATOR_DEFINES_SVH
`define TS_PACKET_DECAPSULATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TSPD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ts_packet_decapsulator: check failed");

// Next-cycle implication.
`define TSPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ts_packet_decapsulator: check failed");

`endif

>>> sv/tspd_pkg.sv
// Shared types, codes and tables of the transport packet decapsulator.
package tspd_pkg;

  localparam int unsigned PKT_LEN = 188;
  localparam logic [12:0] PID_OFF = 13'h1FFF;

  localparam logic [1:0] KIND_INNER = 2'd0;
  localparam logic [1:0] KIND_PASS  = 2'd1;
  localparam logic [1:0] KIND_NULL  = 2'd2;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_BAD      = 4'd1;
  localparam logic [3:0] ST_PES_TYPE = 4'd2;
  localparam logic [3:0] ST_PES_SIZE = 4'd3;
  localparam logic [3:0] ST_FLAGS    = 4'd4;
  localparam logic [3:0] ST_SHORT    = 4'd5;
  localparam logic [3:0] ST_KEY      = 4'd6;
  localparam logic [3:0] ST_KLV_LEN  = 4'd7;
  localparam logic [3:0] ST_KLV_PAY  = 4'd8;
  localparam logic [3:0] ST_POINTER  = 4'd9;
  localparam logic [3:0] ST_CC       = 4'd10;

  // Header parse result as seen after the byte now being taken in.
  typedef struct packed {
    logic [3:0] fail;   // first header error, ST_OK if none
    logic       pes;    // PES/KLV envelope recognised
    logic       mark;   // start mark (PUSI or key bit 4)
    logic [7:0] idx;    // offset of the pointer byte, 188 if none
    logic [7:0] ptrb;   // byte at idx
    logic [7:0] frag;   // PES header data length
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } parse_res_t;

  // Copy of payload bytes from the incoming buffer into an assembly bank.
  typedef struct packed {
    logic       go;
    logic       sbank;
    logic       dbank;
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] cnt;
  } copy_cmd_t;

  function automatic logic [7:0] ul_key_byte(logic [3:0] k);
    logic [7:0] v;
    case (k)
      4'd0:    v = 8'h06;
      4'd1:    v = 8'h0E;
      4'd2:    v = 8'h2B;
      4'd3:    v = 8'h34;
      4'd4:    v = 8'h01;
      4'd5:    v = 8'h01;
      4'd6:    v = 8'h01;
      4'd7:    v = 8'h01;
      4'd8:    v = 8'h0F;
      4'd9:    v = 8'h01;
      4'd10:   v = 8'h08;
      4'd11:   v = 8'h00;
      default: v = 8'h0F;
    endcase
    return v;
  endfunction

endpackage

>>> sv/tspd_hdr_parser.sv
// Byte-serial parser of the TS, PES and KLV headers of one incoming packet.
module tspd_hdr_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [7:0]          pos,
  input  logic [7:0]          din,
  output tspd_pkg::parse_res_t res
);
  import tspd_pkg::*;

  typedef enum logic [4:0] {
    S_HDR, S_AFL, S_P0, S_P1, S_P2, S_SID, S_SZ0, S_SZ1, S_FLG, S_SKIP,
    S_HLEN, S_KEY, S_LEN, S_LEN2, S_PTR, S_DONE, S_PLAIN, S_FAIL
  } pstate_t;

  pstate_t    st, st_next;
  logic [7:0] tgt, tgt_next, i0, i0_next, ptrb, ptrb_next, frag, frag_next;
  logic [7:0] b1, b1_next, b2, b2_next, b3, b3_next;
  logic [3:0] k, k_next, fcode, fcode_next;
  logic       mark, mark_next;
  logic       hit;
  logic [8:0] t9;

  always_comb begin
    st_next    = st;
    tgt_next   = tgt;
    i0_next    = i0;
    ptrb_next  = ptrb;
    frag_next  = frag;
    b1_next    = b1;
    b2_next    = b2;
    b3_next    = b3;
    k_next     = k;
    fcode_next = fcode;
    mark_next  = mark;
    hit        = (pos == tgt);
    t9         = '0;
    if (pos == 8'd0) begin
      st_next    = S_HDR;
      fcode_next = ST_OK;
      mark_next  = 1'b0;
      frag_next  = '0;
    end else if (pos == 8'd1) begin
      b1_next = din;
    end else if (pos == 8'd2) begin
      b2_next = din;
    end else if (pos == 8'd3) begin
      b3_next  = din;
      tgt_next = 8'd4;
      st_next  = din[5] ? S_AFL : S_P0;
    end else if (hit) begin
      case (st)
        S_AFL: begin
          t9       = 9'd5 + {1'b0, din};
          tgt_next = (t9 > 9'd188) ? 8'd188 : t9[7:0];
          st_next  = S_P0;
        end
        S_P0: begin
          i0_next   = tgt;
          ptrb_next = din;
          if (b1[6] && tgt < 8'd179 && din == 8'h00) begin
            st_next  = S_P1;
            tgt_next = tgt + 8'd1;
          end else begin
            st_next = S_PLAIN;
          end
        end
        S_P1, S_P2: begin
          if (din == ((st == S_P1) ? 8'h00 : 8'h01)) begin
            st_next  = (st == S_P1) ? S_P2 : S_SID;
            tgt_next = tgt + 8'd1;
          end else begin
            st_next  = S_PLAIN;
            tgt_next = i0;
          end
        end
        S_SID: begin
          tgt_next = tgt + 8'd1;
          if (din == 8'hBD) st_next = S_SZ0;
          else begin
            st_next    = S_FAIL;
            fcode_next = ST_PES_TYPE;
          end
        end
        S_SZ0: begin
          tgt_next = tgt + 8'd1;
          if (din == 8'h00) st_next = S_SZ1;
          else begin
            st_next    = S_FAIL;
            fcode_next = ST_PES_SIZE;
          end
        end
        S_SZ1: begin
          tgt_next = tgt + 8'd1;
          if (din >= 8'd18) st_next = S_FLG;
          else begin
            st_next    = S_FAIL;
            fcode_next = ST_PES_SIZE;
          end
        end
        S_FLG: begin
          tgt_next = tgt + 8'd1;
          if (din == 8'h80 || din == 8'h84) st_next = S_SKIP;
          else begin
            st_next    = S_FAIL;
            fcode_next = ST_FLAGS;
          end
        end
        S_SKIP: begin
          tgt_next = tgt + 8'd1;
          st_next  = S_HLEN;
        end
        S_HLEN: begin
          // key starts right after the PES header data
          t9        = {1'b0, tgt} + 9'd1 + {1'b0, din};
          frag_next = din;
          if (t9 > 9'd170) begin
            st_next    = S_FAIL;
            fcode_next = ST_SHORT;
          end else begin
            tgt_next = t9[7:0];
            k_next   = '0;
            st_next  = S_KEY;
          end
        end
        S_KEY: begin
          tgt_next = tgt + 8'd1;
          if (k == 4'd15) begin
            if (din == 8'h0F || din == 8'h1F) begin
              mark_next = din[4];
              st_next   = S_LEN;
            end else begin
              st_next    = S_FAIL;
              fcode_next = ST_KEY;
            end
          end else if (din == ul_key_byte(k)) begin
            k_next = k + 4'd1;
          end else begin
            st_next    = S_FAIL;
            fcode_next = ST_KEY;
          end
        end
        S_LEN: begin
          tgt_next = tgt + 8'd1;
          if (!din[7]) st_next = S_PTR;
          else if (din == 8'h81) st_next = S_LEN2;
          else begin
            st_next    = S_FAIL;
            fcode_next = ST_KLV_LEN;
          end
        end
        S_LEN2: begin
          tgt_next = tgt + 8'd1;
          if (din > 8'd188) begin
            st_next    = S_FAIL;
            fcode_next = ST_KLV_PAY;
          end else begin
            st_next = S_PTR;
          end
        end
        S_PTR: begin
          ptrb_next = din;
          st_next   = S_DONE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_HDR;
      fcode <= ST_OK;
      mark  <= 1'b0;
    end else if (en) begin
      st    <= st_next;
      fcode <= fcode_next;
      mark  <= mark_next;
    end
    if (en) begin
      tgt  <= tgt_next;
      i0   <= i0_next;
      ptrb <= ptrb_next;
      frag <= frag_next;
      b1   <= b1_next;
      b2   <= b2_next;
      b3   <= b3_next;
      k    <= k_next;
    end
  end

  always_comb begin
    res.fail = fcode_next;
    res.pes  = (st_next == S_PTR) || (st_next == S_DONE);
    res.mark = res.pes ? mark_next : b1_next[6];
    res.idx  = tgt_next;
    res.ptrb = ptrb_next;
    res.frag = frag_next;
    res.b1   = b1_next;
    res.b2   = b2_next;
    res.b3   = b3_next;
  end

endmodule

>>> sv/tspd_buffers.sv
// Incoming and assembly packet memories with the payload copy engine.
module tspd_buffers (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_we,
  input  logic [8:0]         in_waddr,
  input  logic [7:0]         in_wdata,
  input  logic               rd_en,
  input  logic [8:0]         inc_raddr,
  input  logic [8:0]         asm_raddr,
  input  tspd_pkg::copy_cmd_t cmd,
  output logic [7:0]         inc_q,
  output logic [7:0]         asm_q
);
  import tspd_pkg::*;
  `include "ts_packet_decapsulator_defines.svh"

  // two banks of 256 each, bank bit on top
  logic [7:0] inc_mem [512];
  logic [7:0] asm_mem [512];

  logic [7:0] cp_cnt, cp_src, cp_dst;
  logic       cp_sb, cp_db;
  logic       cpw_valid;
  logic [8:0] cpw_addr;
  logic [7:0] cp_q;

  always_ff @(posedge clk) begin
    if (in_we) inc_mem[in_waddr] <= in_wdata;
    if (rd_en) inc_q <= inc_mem[inc_raddr];
    cp_q <= inc_mem[{cp_sb, cp_src}];
  end

  always_ff @(posedge clk) begin
    if (cpw_valid) asm_mem[cpw_addr] <= cp_q;
    if (rd_en) asm_q <= asm_mem[asm_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cp_cnt    <= '0;
      cpw_valid <= 1'b0;
    end else if (cmd.go) begin
      cp_cnt    <= cmd.cnt;
      cp_src    <= cmd.src;
      cp_dst    <= cmd.dst;
      cp_sb     <= cmd.sbank;
      cp_db     <= cmd.dbank;
      cpw_valid <= 1'b0;
    end else if (cp_cnt != 8'd0) begin
      cpw_valid <= 1'b1;
      cpw_addr  <= {cp_db, cp_dst};
      cp_src    <= cp_src + 8'd1;
      cp_dst    <= cp_dst + 8'd1;
      cp_cnt    <= cp_cnt - 8'd1;
    end else begin
      cpw_valid <= 1'b0;
    end
  end

  // a new packet is judged only after the previous copy has drained
  `TSPD_ASSERT_IMPL(a_copy_idle, cmd.go, cp_cnt == 8'd0 && !cpw_valid)

endmodule

>>> sv/ts_packet_decapsulator.sv
// Top level of the transport packet decapsulator.
// Takes one byte per cycle while the output is not stalled and gives one result
// byte per accepted byte while a slot is valid, registered in the cycle after its
// input byte; a packet is judged on its last byte and its slot (inner, passed or
// null packet) comes out during the next packet. Payload moves into the
// double-banked assembly memory through a copy engine on a second read port of
// the incoming memory after each judgement. No clearing pass is needed after reset.
module ts_packet_decapsulator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,   // input_pid
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // data_byte
  input  logic [0:0]  s_tuser,     // packet_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,     // out_byte
  output logic        m_tlast,     // out_last
  output logic [6:0]  m_tuser      // out_first, out_kind[1:0], status[3:0]
);
  import tspd_pkg::*;
  `include "ts_packet_decapsulator_defines.svh"

  typedef enum logic [1:0] {SRC_CONST, SRC_ASM, SRC_INC} src_t;

  logic [12:0] input_pid;
  logic [7:0]  bp, pos, fill, fill_eff, fill_next;
  logic        in_sync, emit_valid, emit_eff, wbank, cur;
  logic [3:0]  last_cc, cc;
  logic        acc, proc, judge, emit;

  logic [1:0]  slot_kind;
  logic [3:0]  slot_status;
  logic [7:0]  slot_f, slot_s;
  logic        slot_abank, slot_ibank;

  parse_res_t  pr;
  copy_cmd_t   cmd;
  logic [12:0] pid;
  logic        pass, bad, ptr_ok, f9, brk, sync_eff, complete;
  logic [8:0]  idx_a, sum9, lim9;
  logic [7:0]  ptr8, sat_s, s8;

  src_t        out_src, src_sel;
  logic [7:0]  out_const, const_sel, inc_ra;
  logic        out_first, out_last;
  logic [1:0]  out_kind;
  logic [3:0]  out_status;
  logic [7:0]  inc_q, asm_q;

  assign s_tready = !m_tvalid || m_tready;
  assign acc      = s_tvalid && s_tready;
  assign proc     = acc && (s_tuser[0] || bp != 8'd0);
  assign pos      = s_tuser[0] ? 8'd0 : bp;
  assign emit_eff = emit_valid && !(s_tuser[0] && bp != 8'd0);
  assign emit     = proc && emit_eff;
  assign judge    = proc && pos == 8'd187;

  tspd_hdr_parser u_parser (
    .clk (clk),
    .rst (rst),
    .en  (proc),
    .pos (pos),
    .din (s_tdata),
    .res (pr)
  );

  // judgement of the packet completed by this byte
  always_comb begin
    pid      = {pr.b1[4:0], pr.b2};
    pass     = (input_pid == PID_OFF) || (pid != input_pid);
    bad      = pr.b1[7] || (pr.b3[7:6] != 2'b00) || !pr.b3[4];
    ptr_ok   = pr.mark && pr.idx < 8'd188;
    idx_a    = {1'b0, pr.idx} + {8'd0, ptr_ok};
    ptr8     = ptr_ok ? pr.ptrb : 8'd0;
    sum9     = idx_a + {1'b0, ptr8};
    lim9     = 9'd188 + {1'b0, (pr.pes ? pr.frag : 8'd0)};
    f9       = pr.mark && (sum9 > lim9);
    cc       = pr.b3[3:0];
    brk      = in_sync && (cc != last_cc + 4'd1);
    sync_eff = in_sync && !brk;
    fill_eff = brk ? 8'd1 : fill;
    sat_s    = (sum9 > 9'd188) ? 8'd188 : sum9[7:0];
    s8       = sync_eff ? idx_a[7:0] : sat_s;
    complete = s8 <= fill_eff;
    cmd      = '0;
    cmd.sbank = wbank;
    if (complete) begin
      cmd.dbank = !cur;
      cmd.dst   = 8'd1;
      cmd.src   = s8 + 8'd188 - fill_eff;
      cmd.cnt   = fill_eff - s8;
      fill_next = 8'd1 + fill_eff - s8;
    end else begin
      cmd.dbank = cur;
      cmd.dst   = fill_eff;
      cmd.src   = s8;
      cmd.cnt   = 8'd188 - s8;
      fill_next = fill_eff + (8'd188 - s8);
    end
    cmd.go = judge && !pass && !bad && pr.fail == ST_OK && !f9 && (sync_eff || pr.mark);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_pid  <= PID_OFF;
      bp         <= '0;
      emit_valid <= 1'b0;
      fill       <= 8'd1;
      in_sync    <= 1'b0;
      last_cc    <= '0;
      wbank      <= 1'b0;
      cur        <= 1'b0;
      slot_kind  <= KIND_INNER;
      slot_status <= ST_OK;
    end else begin
      if (cfg_we) input_pid <= cfg_wdata;
      if (proc) begin
        bp         <= (pos == 8'd187) ? 8'd0 : pos + 8'd1;
        emit_valid <= (pos == 8'd187) ? 1'b1 : emit_eff;
      end
      if (judge) begin
        wbank      <= !wbank;
        slot_ibank <= wbank;
        slot_abank <= cur;
        slot_f     <= fill_eff;
        slot_s     <= s8;
        if (pass) begin
          slot_kind   <= KIND_PASS;
          slot_status <= ST_OK;
        end else if (bad || pr.fail != ST_OK || f9) begin
          in_sync     <= 1'b0;
          fill        <= 8'd1;
          slot_kind   <= KIND_NULL;
          slot_status <= bad ? ST_BAD : (pr.fail != ST_OK) ? pr.fail : ST_POINTER;
        end else begin
          last_cc     <= cc;
          slot_status <= brk ? ST_CC : ST_OK;
          if (!sync_eff && !pr.mark) begin
            in_sync   <= 1'b0;
            fill      <= fill_eff;
            slot_kind <= KIND_NULL;
          end else begin
            in_sync   <= 1'b1;
            fill      <= fill_next;
            slot_kind <= complete ? KIND_INNER : KIND_NULL;
            if (complete) cur <= !cur;
          end
        end
      end
    end
  end

  // slot byte selection for the current position
  always_comb begin
    inc_ra    = (slot_kind == KIND_PASS) ? pos : slot_s + pos - slot_f;
    const_sel = 8'h47;
    src_sel   = SRC_CONST;
    case (slot_kind)
      KIND_PASS: src_sel = SRC_INC;
      KIND_INNER: begin
        if (pos == 8'd0) src_sel = SRC_CONST;
        else if (pos < slot_f) src_sel = SRC_ASM;
        else src_sel = SRC_INC;
      end
      default: begin
        case (pos)
          8'd0:    const_sel = 8'h47;
          8'd1:    const_sel = 8'h1F;
          8'd3:    const_sel = 8'h10;
          default: const_sel = 8'hFF;
        endcase
      end
    endcase
  end

  tspd_buffers u_buffers (
    .clk       (clk),
    .rst       (rst),
    .in_we     (proc),
    .in_waddr  ({wbank, pos}),
    .in_wdata  (s_tdata),
    .rd_en     (emit),
    .inc_raddr ({slot_ibank, inc_ra}),
    .asm_raddr ({slot_abank, pos}),
    .cmd       (cmd),
    .inc_q     (inc_q),
    .asm_q     (asm_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (emit) begin
      out_src    <= src_sel;
      out_const  <= const_sel;
      out_first  <= (pos == 8'd0);
      out_last   <= (pos == 8'd187);
      out_kind   <= slot_kind;
      out_status <= slot_status;
    end
  end

  always_comb begin
    case (out_src)
      SRC_ASM: m_tdata = asm_q;
      SRC_INC: m_tdata = inc_q;
      default: m_tdata = out_const;
    endcase
  end

  assign m_tlast = out_last;
  assign m_tuser = {out_status, out_kind, out_first};

  `TSPD_ASSERT_NEXT(a_emit_valid, emit, m_tvalid)
  `TSPD_ASSERT_NEXT(a_emit_first, emit && pos == 8'd0, m_tuser[0] && !m_tlast)
  `TSPD_ASSERT_IMPL(a_fill_range, judge, fill >= 8'd1 && fill <= 8'd187)

endmodule
